>>> sv/rptc_pkg.sv
package rptc_pkg;

  // pulse store geometry
  localparam int STORE_DEPTH = 512;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PACKET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DIV  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_HOLD = 3'd4;

  localparam logic [15:0] RST_MIN_PULSE   = 16'd150;
  localparam logic [19:0] RST_GAP_TIMEOUT = 20'd7000;
  localparam logic [9:0]  RST_MIN_PACKET  = 10'd50;
  localparam logic [7:0]  RST_SAMPLE_DIV  = 8'd30;
  localparam logic [15:0] RST_REPEAT_HOLD = 16'd250;

  // item function codes
  localparam logic [1:0] FUNC_EDGE    = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;

  // result status codes
  localparam logic [3:0] ST_IGNORED  = 4'd0;
  localparam logic [3:0] ST_REPEAT   = 4'd1;
  localparam logic [3:0] ST_NOISE    = 4'd2;
  localparam logic [3:0] ST_STORED   = 4'd3;
  localparam logic [3:0] ST_OVERFLOW = 4'd4;
  localparam logic [3:0] ST_SYNC     = 4'd5;
  localparam logic [3:0] ST_PACKET   = 4'd6;
  localparam logic [3:0] ST_READ     = 4'd7;
  localparam logic [3:0] ST_RELEASED = 4'd8;

  // stored value offset and saturation
  localparam logic [31:0] UNIT_OFFSET = 32'd4;
  localparam logic [31:0] SAT_LIMIT   = 32'd65535 - UNIT_OFFSET;

  // serial divider
  localparam int DVD_W     = 32;
  localparam int DVR_W     = 8;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PULSE,
    S_DECIDE,
    S_CHECK,
    S_DIV,
    S_WRITE,
    S_POST,
    S_FINISH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       calc_pulse;
    logic       take_edge;
    logic       clear_repeat;
    logic       clr_count;
    logic       set_count_one;
    logic       div_start;
    logic       wr_pulse;
    logic       wr_term;
    logic       release_blk;
    logic       mem_rd;
    logic       load_out;
    logic [3:0] code;
  } rptc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       busy;
    logic       rep_active;
    logic       rep_skip;
    logic       pulse_short;
    logic       pulse_gap;
    logic       can_store;
    logic       cnt_full;
    logic       cnt_pk;
    logic       div_busy;
  } rptc_stat_t;

endpackage

>>> sv/rptc_if.sv
// input channel
interface rptc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] time_us;
  logic [31:0] now_ms;
  logic        suppress_repeats;
  logic [8:0]  read_index;

  modport source (
    output valid, func, time_us, now_ms, suppress_repeats, read_index,
    input  ready
  );
  modport sink (
    input  valid, func, time_us, now_ms, suppress_repeats, read_index,
    output ready
  );
endinterface

// result channel
interface rptc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [8:0]  packet_length;
  logic [15:0] read_value;

  modport source (
    output valid, status, packet_length, read_value,
    input  ready
  );
  modport sink (
    input  valid, status, packet_length, read_value,
    output ready
  );
endinterface

>>> sv/rptc_div.sv
module rptc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rptc_pkg::DVD_W-1:0]  dividend,
  input  logic [rptc_pkg::DVR_W-1:0]  divisor,
  output logic [rptc_pkg::DVD_W-1:0]  quotient,
  output logic                        busy
);

  logic [rptc_pkg::DVD_W-1:0]     quo_r, quo_nxt;
  logic [rptc_pkg::DVR_W-1:0]     rem_r, rem_nxt;
  logic [rptc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic [rptc_pkg::DVR_W:0]       trial;
  logic                           fits;

  // one restoring step per cycle
  always_comb begin
    trial    = {rem_r, quo_r[rptc_pkg::DVD_W-1]};
    fits     = trial >= {1'b0, divisor};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = rptc_pkg::DIV_CNT_W'(rptc_pkg::DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[rptc_pkg::DVD_W-2:0], fits};
      rem_nxt = fits ? rptc_pkg::DVR_W'(trial - {1'b0, divisor})
                     : trial[rptc_pkg::DVR_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == rptc_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = quo_r;
  assign busy     = busy_r;

endmodule

>>> sv/rptc_dpath.sv
module rptc_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rptc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rptc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [1:0]                        in_func,
  input  logic [31:0]                       in_time_us,
  input  logic [31:0]                       in_now_ms,
  input  logic                              in_suppress_repeats,
  input  logic [8:0]                        in_read_index,
  input  rptc_pkg::rptc_cmd_t               cmd,
  output rptc_pkg::rptc_stat_t              st,
  output logic [3:0]                        out_status,
  output logic [8:0]                        out_packet_length,
  output logic [15:0]                       out_read_value
);

  // configuration registers
  logic [15:0] min_pulse_r;
  logic [19:0] gap_timeout_r;
  logic [9:0]  min_packet_r;
  logic [7:0]  sample_div_r;
  logic [15:0] repeat_hold_r;

  // item held for the duration of its work
  logic [1:0]  func_r;
  logic [31:0] time_r;
  logic [31:0] now_r;
  logic        arm_r;
  logic [8:0]  ridx_r;

  // capture state
  logic [31:0]                   last_edge_r;
  logic [rptc_pkg::CNT_W-1:0]    count_r;
  logic                          busy_r;
  logic                          rep_active_r;
  logic [31:0]                   deadline_r;
  logic [31:0]                   pulse_r;
  logic [8:0]                    plen_r;

  // pulse store
  logic [15:0] store_mem [rptc_pkg::STORE_DEPTH];
  logic [15:0] rdata_r;

  // result register
  logic [3:0]  status_r;
  logic [8:0]  plen_out_r;
  logic [15:0] rval_out_r;

  logic [7:0]                   div_eff;
  logic [9:0]                   minpk_eff;
  logic [31:0]                  quotient;
  logic                         div_busy;
  logic [15:0]                  sat_val;
  logic [rptc_pkg::ADDR_W-1:0]  wr_addr;
  logic [rptc_pkg::ADDR_W-1:0]  rd_addr;
  logic                         rd_in_range;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r   <= rptc_pkg::RST_MIN_PULSE;
      gap_timeout_r <= rptc_pkg::RST_GAP_TIMEOUT;
      min_packet_r  <= rptc_pkg::RST_MIN_PACKET;
      sample_div_r  <= rptc_pkg::RST_SAMPLE_DIV;
      repeat_hold_r <= rptc_pkg::RST_REPEAT_HOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        rptc_pkg::CFG_MIN_PULSE:   min_pulse_r   <= cfg_wdata[15:0];
        rptc_pkg::CFG_GAP_TIMEOUT: gap_timeout_r <= cfg_wdata[19:0];
        rptc_pkg::CFG_MIN_PACKET:  min_packet_r  <= cfg_wdata[9:0];
        rptc_pkg::CFG_SAMPLE_DIV:  sample_div_r  <= cfg_wdata[7:0];
        rptc_pkg::CFG_REPEAT_HOLD: repeat_hold_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // zero divisor and zero packet minimum act as one
  assign div_eff   = (sample_div_r == '0) ? 8'd1 : sample_div_r;
  assign minpk_eff = (min_packet_r == '0) ? 10'd1 : min_packet_r;

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      time_r <= in_time_us;
      now_r  <= in_now_ms;
      arm_r  <= in_suppress_repeats;
      ridx_r <= in_read_index;
    end
  end

  // pulse length, wrapping difference
  always_ff @(posedge clk) begin
    if (cmd.calc_pulse) begin
      pulse_r <= time_r - last_edge_r;
    end
  end

  rptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (pulse_r),
    .divisor  (div_eff),
    .quotient (quotient),
    .busy     (div_busy)
  );

  // saturated stored unit
  assign sat_val = (quotient > rptc_pkg::SAT_LIMIT) ? 16'hFFFF
                                                    : 16'(quotient + rptc_pkg::UNIT_OFFSET);

  // capture state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r  <= '0;
      count_r      <= rptc_pkg::CNT_W'(1);
      busy_r       <= 1'b0;
      rep_active_r <= 1'b0;
      deadline_r   <= '0;
    end else begin
      if (cmd.take_edge) begin
        last_edge_r <= time_r;
      end
      if (cmd.clear_repeat) begin
        rep_active_r <= 1'b0;
        count_r      <= rptc_pkg::CNT_W'(1);
      end else if (cmd.clr_count) begin
        count_r <= '0;
      end else if (cmd.set_count_one) begin
        count_r <= rptc_pkg::CNT_W'(1);
      end else if (cmd.wr_pulse) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.wr_term) begin
        count_r <= '0;
        busy_r  <= 1'b1;
      end else if (cmd.release_blk) begin
        busy_r       <= 1'b0;
        rep_active_r <= arm_r;
        if (arm_r) begin
          deadline_r <= now_r + 32'(repeat_hold_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_term) begin
      plen_r <= 9'(count_r - 1'b1);
    end
  end

  // pulse store, one write and one registered read port
  assign wr_addr     = count_r[rptc_pkg::ADDR_W-1:0];
  assign rd_addr     = rptc_pkg::ADDR_W'(ridx_r);
  assign rd_in_range = 32'(ridx_r) < 32'(rptc_pkg::STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.wr_pulse) begin
      store_mem[wr_addr] <= sat_val;
    end else if (cmd.wr_term) begin
      store_mem[wr_addr] <= '0;
    end
    if (cmd.mem_rd) begin
      rdata_r <= store_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r   <= cmd.code;
      plen_out_r <= (cmd.code == rptc_pkg::ST_PACKET) ? plen_r : '0;
      rval_out_r <= (cmd.code == rptc_pkg::ST_READ && rd_in_range) ? rdata_r : '0;
    end
  end

  assign out_status        = status_r;
  assign out_packet_length = plen_out_r;
  assign out_read_value    = rval_out_r;

  // status towards the controller
  always_comb begin
    st.func        = func_r;
    st.busy        = busy_r;
    st.rep_active  = rep_active_r;
    st.rep_skip    = (deadline_r > now_r) && (pulse_r < 32'({gap_timeout_r, 2'b00}));
    st.pulse_short = pulse_r < 32'(min_pulse_r);
    st.pulse_gap   = pulse_r >= 32'(gap_timeout_r);
    st.can_store   = (count_r != '0) && (32'(count_r) < 32'(rptc_pkg::STORE_DEPTH));
    st.cnt_full    = 32'(count_r) >= 32'(rptc_pkg::STORE_DEPTH);
    st.cnt_pk      = 32'(count_r) >= 32'(minpk_eff);
    st.div_busy    = div_busy;
  end

endmodule

>>> sv/rptc_ctrl.sv
module rptc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  rptc_pkg::rptc_stat_t  st,
  output rptc_pkg::rptc_cmd_t   cmd
);

  rptc_pkg::ctrl_state_t state_r, state_nxt;
  logic [3:0]            code_r, code_nxt;
  logic                  stored_r, stored_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == rptc_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rptc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = rptc_pkg::S_PULSE;
      end
      rptc_pkg::S_PULSE: state_nxt = rptc_pkg::S_DECIDE;
      rptc_pkg::S_DECIDE: begin
        if (st.func == rptc_pkg::FUNC_EDGE && !st.busy &&
            !(st.rep_active && st.rep_skip)) begin
          state_nxt = rptc_pkg::S_CHECK;
        end else begin
          state_nxt = rptc_pkg::S_FINISH;
        end
      end
      rptc_pkg::S_CHECK: begin
        if (st.pulse_short)    state_nxt = rptc_pkg::S_FINISH;
        else if (st.can_store) state_nxt = rptc_pkg::S_DIV;
        else                   state_nxt = rptc_pkg::S_POST;
      end
      rptc_pkg::S_DIV: begin
        if (!st.div_busy) state_nxt = rptc_pkg::S_WRITE;
      end
      rptc_pkg::S_WRITE: state_nxt = rptc_pkg::S_POST;
      rptc_pkg::S_POST:  state_nxt = rptc_pkg::S_FINISH;
      rptc_pkg::S_FINISH: begin
        if (slot_free) state_nxt = rptc_pkg::S_IDLE;
      end
      default: state_nxt = rptc_pkg::S_IDLE;
    endcase
  end

  // commands and result code
  always_comb begin
    cmd        = '0;
    cmd.code   = code_r;
    code_nxt   = code_r;
    stored_nxt = stored_r;
    case (state_r)
      rptc_pkg::S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) stored_nxt = 1'b0;
      end
      rptc_pkg::S_PULSE: cmd.calc_pulse = 1'b1;
      rptc_pkg::S_DECIDE: begin
        case (st.func)
          rptc_pkg::FUNC_EDGE: begin
            if (st.busy) begin
              code_nxt = rptc_pkg::ST_IGNORED;
            end else if (st.rep_active && st.rep_skip) begin
              cmd.take_edge = 1'b1;
              code_nxt      = rptc_pkg::ST_REPEAT;
            end else begin
              cmd.take_edge    = 1'b1;
              cmd.clear_repeat = st.rep_active;
            end
          end
          rptc_pkg::FUNC_RELEASE: begin
            cmd.release_blk = 1'b1;
            code_nxt        = rptc_pkg::ST_RELEASED;
          end
          rptc_pkg::FUNC_READ: begin
            cmd.mem_rd = 1'b1;
            code_nxt   = rptc_pkg::ST_READ;
          end
          default: code_nxt = rptc_pkg::ST_IGNORED;
        endcase
      end
      rptc_pkg::S_CHECK: begin
        if (st.pulse_short) begin
          cmd.clr_count = 1'b1;
          code_nxt      = rptc_pkg::ST_NOISE;
        end else if (st.can_store) begin
          cmd.div_start = 1'b1;
        end
      end
      rptc_pkg::S_DIV: ;
      rptc_pkg::S_WRITE: begin
        cmd.wr_pulse = 1'b1;
        stored_nxt   = 1'b1;
      end
      rptc_pkg::S_POST: begin
        if (st.cnt_full) begin
          cmd.clr_count = 1'b1;
          code_nxt      = rptc_pkg::ST_OVERFLOW;
        end else if (st.pulse_gap && st.cnt_pk) begin
          cmd.wr_term = 1'b1;
          code_nxt    = rptc_pkg::ST_PACKET;
        end else if (st.pulse_gap) begin
          cmd.set_count_one = 1'b1;
          code_nxt          = rptc_pkg::ST_SYNC;
        end else begin
          code_nxt = stored_r ? rptc_pkg::ST_STORED : rptc_pkg::ST_IGNORED;
        end
      end
      rptc_pkg::S_FINISH: cmd.load_out = slot_free;
      default: ;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rptc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      code_r      <= rptc_pkg::ST_IGNORED;
      stored_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      code_r      <= code_nxt;
      stored_r    <= stored_nxt;
    end
  end

  // an accepted beat closes the input until its work is done
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item was in work");

  // a pulse is only written to a free store slot
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_pulse |-> st.can_store)
    else $error("pulse write with count out of range");

  // the quotient is complete before it is stored
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rptc_pkg::S_WRITE) |-> !st.div_busy)
    else $error("store write while divider running");

  // closing a packet leaves the block busy
  a_packet_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_term |=> st.busy)
    else $error("packet closed without busy");

  // a loaded result is offered on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("loaded result not offered");

endmodule

>>> sv/rf_pulse_train_capture_unit.sv
// Pulse train capture: each input beat is an edge event, a release or a store read (other
// function codes are answered as ignored), and gives exactly one result beat. An edge that
// stores a pulse waits on the bit-serial divider, which forms length / sample_divisor one
// quotient bit per cycle. One item is worked on at a time; the result sits in an output
// register, so the next item is accepted while that result waits to be taken, and it holds
// in its last cycle until the waiting result has gone. Store entries that were never
// written (entry 0 among them) read back undefined.
module rf_pulse_train_capture_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  rptc_in_if.sink                          in_ch,
  rptc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [rptc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rptc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  rptc_pkg::rptc_cmd_t  cmd;
  rptc_pkg::rptc_stat_t st;

  // sequencing
  rptc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // registers, store and divider
  rptc_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_func             (in_ch.func),
    .in_time_us          (in_ch.time_us),
    .in_now_ms           (in_ch.now_ms),
    .in_suppress_repeats (in_ch.suppress_repeats),
    .in_read_index       (in_ch.read_index),
    .cmd                 (cmd),
    .st                  (st),
    .out_status          (out_ch.status),
    .out_packet_length   (out_ch.packet_length),
    .out_read_value      (out_ch.read_value)
  );

endmodule

>>> tb/capture_result_checker.sv
`timescale 1ns / 100ps
module capture_result_checker
  import rptc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  rptc_in_if                     in_ch,
  rptc_out_if                    out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     pending,
  output int                     fail_count,
  output logic [STORE_DEPTH-1:0] written_map
);

  typedef struct packed {
    logic [3:0]  status;
    logic [8:0]  packet_length;
    logic [15:0] read_value;
  } capture_result_t;

  localparam int PRINT_LIMIT = 40;

  // settings as last written
  logic [15:0] min_pulse;
  logic [19:0] gap_us;
  logic [9:0]  min_pk;
  logic [7:0]  unit_div;
  logic [15:0] hold_ms;

  // mirrored capture state
  logic [31:0]            last_edge;
  int unsigned            held_count;
  logic [15:0]            pulse_copy [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] entry_written;
  logic                   busy_q;
  logic                   repeat_on;
  logic [31:0]            repeat_until;

  capture_result_t results_due [$];
  int              mismatches = 0;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < PRINT_LIMIT) begin
      $display("checker: %s: got %0d, expected %0d at %0t", what, got, want, $time);
    end
    mismatches++;
  endtask

  task automatic reset_capture_state();
    min_pulse     = RST_MIN_PULSE;
    gap_us        = RST_GAP_TIMEOUT;
    min_pk        = RST_MIN_PACKET;
    unit_div      = RST_SAMPLE_DIV;
    hold_ms       = RST_REPEAT_HOLD;
    last_edge     = '0;
    held_count    = 1;
    entry_written = '0;
    busy_q        = 1'b0;
    repeat_on     = 1'b0;
    repeat_until  = '0;
  endtask

  // one edge event: pulse length, repeat gate, noise, store, framing
  task automatic predict_edge(input logic [31:0] t, input logic [31:0] now,
                              output logic [3:0] status, output logic [8:0] plen);
    logic [31:0] pulse;
    logic [31:0] quot;
    logic [32:0] units;
    int unsigned divisor;
    int unsigned pk_min;
    bit          wrote;
    pulse   = t - last_edge;
    divisor = (unit_div == 0) ? 1 : unit_div;
    pk_min  = (min_pk == 0) ? 1 : min_pk;
    wrote   = 1'b0;
    plen    = '0;
    status  = ST_IGNORED;
    last_edge = t;

    // repeat suppression ends on a very long gap or at the deadline
    if (repeat_on) begin
      if (repeat_until > now && {2'b00, pulse} < 34'({gap_us, 2'b00})) begin
        status = ST_REPEAT;
        return;
      end
      repeat_on  = 1'b0;
      held_count = 1;
    end

    if (pulse < min_pulse) begin
      held_count = 0;
      status = ST_NOISE;
      return;
    end

    // store 4 + length / divisor, saturated
    if (held_count != 0 && held_count < STORE_DEPTH) begin
      quot  = pulse / divisor;
      units = {1'b0, quot} + 33'd4;
      pulse_copy[held_count]    = (units > 33'd65535) ? 16'hFFFF : units[15:0];
      entry_written[held_count] = 1'b1;
      held_count++;
      wrote = 1'b1;
    end

    if (held_count >= STORE_DEPTH) begin
      held_count = 0;
      status = ST_OVERFLOW;
      return;
    end

    // long gap: close a packet or restart capture
    if (pulse >= gap_us) begin
      if (held_count >= pk_min) begin
        pulse_copy[held_count]    = '0;
        entry_written[held_count] = 1'b1;
        plen       = 9'(held_count - 1);
        busy_q     = 1'b1;
        held_count = 0;
        status     = ST_PACKET;
        return;
      end
      held_count = 1;
      status = ST_SYNC;
      return;
    end

    status = wrote ? ST_STORED : ST_IGNORED;
  endtask

  task automatic predict_capture(input logic [1:0] func, input logic [31:0] t,
                                 input logic [31:0] now, input logic arm,
                                 input logic [8:0] idx, output capture_result_t res);
    logic [3:0] st;
    logic [8:0] pl;
    res = '0;
    res.status = ST_IGNORED;
    case (func)
      FUNC_EDGE: begin
        if (!busy_q) begin
          predict_edge(t, now, st, pl);
          res.status = st;
          res.packet_length = pl;
        end
      end
      FUNC_RELEASE: begin
        busy_q    = 1'b0;
        repeat_on = arm;
        if (arm) repeat_until = now + 32'(hold_ms);
        res.status = ST_RELEASED;
      end
      FUNC_READ: begin
        res.read_value = pulse_copy[idx];
        res.status = ST_READ;
      end
      default: ;
    endcase
  endtask

  // watch the port and both channels on every edge
  always @(posedge clk) begin
    capture_result_t got;
    capture_result_t want;
    if (!rst_n) begin
      reset_capture_state();
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_PULSE:   min_pulse = cfg_wdata[15:0];
          CFG_GAP_TIMEOUT: gap_us    = cfg_wdata[19:0];
          CFG_MIN_PACKET:  min_pk    = cfg_wdata[9:0];
          CFG_SAMPLE_DIV:  unit_div  = cfg_wdata[7:0];
          CFG_REPEAT_HOLD: hold_ms   = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_capture(in_ch.func, in_ch.time_us, in_ch.now_ms, in_ch.suppress_repeats,
                        in_ch.read_index, want);
        results_due.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.packet_length, out_ch.read_value};
        if (results_due.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", got.status, 0);
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.packet_length !== want.packet_length)
            report_mismatch("packet_length", got.packet_length, want.packet_length);
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
        end
      end
    end
    pending     <= results_due.size();
    fail_count  <= mismatches;
    written_map <= entry_written;
  end

endmodule

>>> tb/rf_pulse_train_capture_unit_tb.sv
`timescale 1ns / 100ps
module rf_pulse_train_capture_unit_tb;
  import rptc_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int IDLE_PCT      = 35;
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 5000;
  localparam int NUM_PHASES    = 8;
  localparam int STEADY_PHASE  = 3;
  localparam int LONG_PHASE    = 2;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int                     pending;
  int                     fail_count;
  logic [STORE_DEPTH-1:0] written_map;

  rptc_in_if  in_ch ();
  rptc_out_if out_ch ();

  bit          steady = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] t_now;
  logic [31:0] now_ms;
  int unsigned cfg_min, cfg_gap, cfg_minpk, cfg_div, cfg_hold;

  rf_pulse_train_capture_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  capture_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .pending     (pending),
    .fail_count  (fail_count),
    .written_map (written_map)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // stall watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input beat, with random idle cycles ahead of it unless steady is set
  task automatic send_beat(input logic [1:0] func, input logic [31:0] t,
                           input logic [31:0] now, input logic arm, input logic [8:0] idx);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.func             <= func;
    in_ch.time_us          <= t;
    in_ch.now_ms           <= now;
    in_ch.suppress_repeats <= arm;
    in_ch.read_index       <= idx;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic send_edge(input logic [31:0] pulse);
    t_now = t_now + pulse;
    send_beat(FUNC_EDGE, t_now, now_ms, 1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)));
  endtask

  task automatic send_release(input logic arm);
    send_beat(FUNC_RELEASE, $urandom(), now_ms, arm, 9'($urandom_range(0, 511)));
  endtask

  // read only entries already written
  task automatic send_read();
    logic [8:0] idx;
    bit         found;
    found = 1'b0;
    idx   = '0;
    for (int k = 0; k < 16 && !found; k++) begin
      idx   = 9'($urandom_range(1, STORE_DEPTH - 1));
      found = written_map[idx];
    end
    if (found) send_beat(FUNC_READ, $urandom(), $urandom(), 1'($urandom_range(0, 1)), idx);
  endtask

  // drain all results, then let the block fall quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic write_regs();
    put_reg(CFG_MIN_PULSE, cfg_min);
    put_reg(CFG_GAP_TIMEOUT, cfg_gap);
    put_reg(CFG_MIN_PACKET, cfg_minpk);
    put_reg(CFG_SAMPLE_DIV, cfg_div);
    put_reg(CFG_REPEAT_HOLD, cfg_hold);
    cfg_we <= 1'b0;
  endtask

  // a gap of at least the timeout, up to reach more timeouts beyond it
  function automatic logic [31:0] span_pulse(input int unsigned reach);
    int unsigned base;
    base = (cfg_gap > cfg_min) ? cfg_gap : cfg_min;
    return base + $urandom_range(0, reach * cfg_gap);
  endfunction

  // a pulse inside a frame, now and then a noise spike
  function automatic logic [31:0] data_pulse();
    if (cfg_min > 0 && $urandom_range(0, 99) < 3) return $urandom_range(0, cfg_min - 1);
    if (cfg_min < cfg_gap) return $urandom_range(cfg_min, cfg_gap - 1);
    return cfg_min + $urandom_range(0, 50);
  endfunction

  // sync gap, pulses, closing gap, now and then a stray edge, then reads and a release
  task automatic send_packet_train(input bit long_frame);
    int unsigned pk_min;
    int unsigned n;
    pk_min = (cfg_minpk == 0) ? 1 : cfg_minpk;
    if (long_frame) n = 510 + $urandom_range(0, 2);
    else if (pk_min > 100) n = $urandom_range(0, 6);
    else n = $urandom_range((pk_min > 2) ? pk_min - 2 : 0, pk_min + 4);
    if ($urandom_range(0, 99) < 60) now_ms = now_ms + cfg_hold + 1;
    send_edge(span_pulse(4));
    for (int i = 0; i < n; i++) begin
      now_ms = now_ms + $urandom_range(0, 2);
      send_edge(data_pulse());
    end
    send_edge(span_pulse(1));
    if ($urandom_range(0, 99) < 30) send_edge($urandom_range(0, 1000));
    repeat ($urandom_range(0, 3)) send_read();
    send_release($urandom_range(0, 99) < 35);
  endtask

  task automatic send_noise_beat();
    case ($urandom_range(0, 3))
      0: begin
        t_now  = $urandom();
        now_ms = $urandom();
        send_beat(FUNC_EDGE, t_now, now_ms, 1'($urandom_range(0, 1)),
                  9'($urandom_range(0, 511)));
      end
      1: send_release(1'($urandom_range(0, 1)));
      2: send_read();
      default: send_beat(FUNC_UNUSED, $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                         9'($urandom_range(0, 511)));
    endcase
  endtask

  task automatic run_directed();
    // reset settings: unknown function, idle release, sync, noise, waiting edge
    send_beat(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 9'h1FF);
    send_release(1'b0);
    send_edge(32'd7000);
    send_edge(32'd100);
    send_edge(32'd200);
    send_edge(32'd7000);
    // wrapped timestamp, stored value saturates
    send_edge(32'hFFFF_FFFF);
    send_edge(32'd149);
    send_edge(32'd150);
    send_beat(FUNC_READ, t_now, now_ms, 1'b0, 9'd1);
    settle();

    // zero divisor, zero packet minimum, no noise floor, gap timeout of 1000000
    cfg_min   = 0;
    cfg_gap   = 1000000;
    cfg_minpk = 0;
    cfg_div   = 0;
    cfg_hold  = 0;
    write_regs();
    send_edge(32'd1000000);
    send_edge(32'd0);
    send_edge(32'd65531);
    send_edge(32'd1000000);
    // busy edge, then terminator and last pulse
    send_edge(32'd5);
    send_beat(FUNC_READ, t_now, now_ms, 1'b0, 9'd4);
    send_beat(FUNC_READ, t_now, now_ms, 1'b0, 9'd3);
    // repeat deadline just ahead, then reached
    now_ms = 32'hFFFF_FFF0;
    send_release(1'b1);
    now_ms = now_ms - 1;
    send_edge(32'd10);
    now_ms = now_ms + 1;
    send_edge(32'd10);
    // very long gap ends suppression before the deadline
    send_release(1'b1);
    now_ms = now_ms - 1;
    send_edge(32'd4000000);
    send_release(1'b0);
  endtask

  task automatic choose_phase(input int p, output int unsigned budget);
    budget = 100;
    case (p)
      0: begin
        cfg_min = 150; cfg_gap = 7000; cfg_minpk = 50; cfg_div = 30; cfg_hold = 250;
        budget = 110;
      end
      1: begin
        cfg_min = 65535; cfg_gap = 1; cfg_minpk = 1; cfg_div = 255; cfg_hold = 65535;
      end
      LONG_PHASE: begin
        cfg_min = 0; cfg_gap = 1000000; cfg_minpk = 512; cfg_div = 1; cfg_hold = 0;
        budget = 580;
      end
      STEADY_PHASE: begin
        cfg_min = 20; cfg_gap = 300; cfg_minpk = 3; cfg_div = 7; cfg_hold = 10;
      end
      4: begin
        cfg_min = 100; cfg_gap = 5000; cfg_minpk = 0; cfg_div = 0; cfg_hold = 65535;
      end
      default: begin
        cfg_min   = $urandom_range(0, 400);
        cfg_gap   = $urandom_range(cfg_min + 1, 30000);
        cfg_minpk = $urandom_range(1, 10);
        cfg_div   = $urandom_range(1, 255);
        cfg_hold  = $urandom_range(0, 3000);
      end
    endcase
  endtask

  initial begin
    int unsigned budget;
    int unsigned first_beat;
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_MIN_PULSE;
    cfg_wdata              <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.func             <= FUNC_EDGE;
    in_ch.time_us          <= '0;
    in_ch.now_ms           <= '0;
    in_ch.suppress_repeats <= 1'b0;
    in_ch.read_index       <= '0;
    t_now  = '0;
    now_ms = '0;
    cfg_min   = RST_MIN_PULSE;
    cfg_gap   = RST_GAP_TIMEOUT;
    cfg_minpk = RST_MIN_PACKET;
    cfg_div   = RST_SAMPLE_DIV;
    cfg_hold  = RST_REPEAT_HOLD;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // random phases, each under its own settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      choose_phase(p, budget);
      write_regs();
      now_ms = $urandom();
      steady = (p == STEADY_PHASE);
      first_beat = beats_sent;
      while (beats_sent - first_beat < budget) begin
        if (p == LONG_PHASE && beats_sent == first_beat) send_packet_train(1'b1);
        else if ($urandom_range(0, 99) < 80) send_packet_train(1'b0);
        else send_noise_beat();
      end
    end
    steady = 1'b0;
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
